[rtl/mcfb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mcfb_pkg;

    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

    typedef logic [IDX_W-1:0] frame_idx_t;

    // Position of each byte in the frame.
    localparam frame_idx_t IDX_HEADER   = frame_idx_t'(0);
    localparam frame_idx_t IDX_LENGTH   = frame_idx_t'(1);
    localparam frame_idx_t IDX_LEFT     = frame_idx_t'(2);
    localparam frame_idx_t IDX_PAD_L    = frame_idx_t'(3);
    localparam frame_idx_t IDX_RIGHT    = frame_idx_t'(4);
    localparam frame_idx_t IDX_PAD_R    = frame_idx_t'(5);
    localparam frame_idx_t IDX_FLAGS    = frame_idx_t'(6);
    localparam frame_idx_t IDX_CRC_LO   = frame_idx_t'(7);
    localparam frame_idx_t IDX_CRC_HI   = frame_idx_t'(8);

    localparam logic [7:0]  HEADER_BYTE = 8'hFF;
    localparam logic [7:0]  LENGTH_BYTE = 8'h07;
    localparam logic [7:0]  PAD_BYTE    = 8'h00;
    localparam logic [7:0]  HIT_SPEED   = 8'd200;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    localparam int unsigned LEFT_FLAG_BIT  = 6;
    localparam int unsigned RIGHT_FLAG_BIT = 4;

    // One byte of the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/motor_command_frame_builder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// command   in         cmd_valid / cmd_stall      left_speed, right_speed, left_dir,
//                                                 right_dir, front_hit, rear_hit
// frame     out        frame_valid / frame_stall  out_byte, last_byte
//
// Each command request becomes nine frame bytes, one per cycle while frame_stall
// is low; the byte-wide frame channel sets that pace. The command passes through
// the holding register, then its header byte enters the output register.
// Reset (rst_n low) empties the holding register and the output register.
// A stalled frame byte holds still; one further command waits in the holding
// register meanwhile, and cmd_stall rises only while that register is full.

module motor_command_frame_builder (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire logic [7:0] left_speed,
    input  wire logic [7:0] right_speed,
    input  wire logic       left_dir,
    input  wire logic       right_dir,
    input  wire logic       front_hit,
    input  wire logic       rear_hit,

    output logic            frame_valid,
    input  wire logic       frame_stall,
    output logic [7:0]      out_byte,
    output logic            last_byte
);
    import mcfb_pkg::*;

    // Holding register: the command after the collision override.
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_ls_reg, hold_rs_reg, hold_flags_reg;

    // Command whose frame is being sent.
    logic [7:0] act_ls_reg, act_rs_reg, act_flags_reg;

    // Running CRC, covering every byte loaded so far from the length byte through the flag byte.
    logic [15:0] crc_reg, crc_next;

    // Output register and the frame position of the byte it holds.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       last_reg, last_next;
    frame_idx_t idx_reg, idx_next;

    logic       cmd_accept;
    logic       advance;
    logic       in_frame;
    logic       start;
    frame_idx_t idx_inc;

    logic [7:0] ovr_ls, ovr_rs, ovr_flags;

    // Front collision alone forces the hit speed with flags clear; rear collision alone
    // forces the hit speed with both flags set; both or neither let the command through.
    always_comb
    begin
        ovr_ls    = left_speed;
        ovr_rs    = right_speed;
        ovr_flags = 8'h00;
        ovr_flags[LEFT_FLAG_BIT]  = left_dir;
        ovr_flags[RIGHT_FLAG_BIT] = right_dir;
        if (front_hit && !rear_hit) begin
            ovr_ls    = HIT_SPEED;
            ovr_rs    = HIT_SPEED;
            ovr_flags = 8'h00;
        end else if (!front_hit && rear_hit) begin
            ovr_ls    = HIT_SPEED;
            ovr_rs    = HIT_SPEED;
            ovr_flags = 8'h00;
            ovr_flags[LEFT_FLAG_BIT]  = 1'b1;
            ovr_flags[RIGHT_FLAG_BIT] = 1'b1;
        end
    end

    // The output register moves on when it is empty or its byte is taken.
    assign advance  = !out_valid_reg || !frame_stall;
    assign in_frame = out_valid_reg && (idx_reg != IDX_CRC_HI);
    assign start    = advance && !in_frame && hold_valid_reg;
    assign idx_inc  = idx_reg + frame_idx_t'(1);

    assign cmd_stall  = hold_valid_reg && !start;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (cmd_accept) begin
            hold_valid_next = 1'b1;
        end else if (start) begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        if (advance) begin
            if (in_frame) begin
                idx_next       = idx_inc;
                out_valid_next = 1'b1;
                last_next      = (idx_inc == IDX_CRC_HI);
                case (idx_inc)
                    IDX_LENGTH: out_byte_next = LENGTH_BYTE;
                    IDX_LEFT:   out_byte_next = act_ls_reg;
                    IDX_PAD_L:  out_byte_next = PAD_BYTE;
                    IDX_RIGHT:  out_byte_next = act_rs_reg;
                    IDX_PAD_R:  out_byte_next = PAD_BYTE;
                    IDX_FLAGS:  out_byte_next = act_flags_reg;
                    IDX_CRC_LO: out_byte_next = crc_reg[7:0];
                    IDX_CRC_HI: out_byte_next = crc_reg[15:8];
                    default:    out_byte_next = HEADER_BYTE;
                endcase
                // The header is left out of the CRC; the two CRC bytes too.
                if (idx_inc != IDX_CRC_LO && idx_inc != IDX_CRC_HI) begin
                    crc_next = crc16_byte(crc_reg, out_byte_next);
                end
            end else if (hold_valid_reg) begin
                idx_next       = IDX_HEADER;
                out_valid_next = 1'b1;
                out_byte_next  = HEADER_BYTE;
                last_next      = 1'b0;
                crc_next       = CRC_INIT;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= IDX_HEADER;
        end else begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept) begin
            hold_ls_reg    <= ovr_ls;
            hold_rs_reg    <= ovr_rs;
            hold_flags_reg <= ovr_flags;
        end
        if (start) begin
            act_ls_reg    <= hold_ls_reg;
            act_rs_reg    <= hold_rs_reg;
            act_flags_reg <= hold_flags_reg;
        end
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        crc_reg      <= crc_next;
    end

    assign frame_valid = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_byte   = last_reg;

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

// Testbench for the motor command frame builder.
//
// Every drive command request that the block takes must come back as a
// nine-byte frame: header, length, left speed, pad, right speed, pad, flag
// byte, then the reflected CRC-16 low byte and high byte. The last byte
// carries last_byte. A collision on one side only replaces the commanded
// speeds and flags; a collision on both sides at once leaves them alone.
//
// The bench predicts each frame when its command is taken and queues the
// nine bytes. Every frame byte taken from the block is compared with the
// oldest queued byte.
module tb;

    import mcfb_pkg::*;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RANDOM_ITEMS  = 350;
    localparam int unsigned CALM_FIRST    = 120;
    localparam int unsigned CALM_LAST     = 220;
    localparam int unsigned IDLE_PERCENT  = 10;
    localparam int unsigned MAX_GAP       = 12;
    localparam int unsigned DRAIN_CYCLES  = 30;
    localparam int unsigned MAX_REPORTS   = 40;
    // The slowest correct run is about 370 commands of 9 bytes, each byte
    // stalled now and then and each command now and then delayed by an idle
    // gap. The limit is set far above what such a run takes.
    localparam int unsigned CYCLE_LIMIT   = 60000;

    localparam logic [7:0] FLAG_NONE  = 8'h00;
    localparam logic [7:0] FLAG_LEFT  = 8'h01 << LEFT_FLAG_BIT;
    localparam logic [7:0] FLAG_RIGHT = 8'h01 << RIGHT_FLAG_BIT;
    localparam logic [7:0] FLAG_BOTH  = FLAG_LEFT | FLAG_RIGHT;

    typedef struct packed {
        logic [7:0] left_speed;
        logic [7:0] right_speed;
        logic       left_dir;
        logic       right_dir;
        logic       front_hit;
        logic       rear_hit;
    } drive_cmd_t;

    typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_t;

    // One row of the directed part. Where typed is set, the speed and flag
    // bytes of the frame are written out by hand; the rest of the frame
    // still follows from them.
    typedef struct {
        drive_cmd_t cmd;
        bit         typed;
        logic [7:0] want_left;
        logic [7:0] want_right;
        logic [7:0] want_flags;
    } plan_row_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         frame_no;
    } frame_byte_t;

    localparam int unsigned PLAN_ROWS = 14;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       left_dir;
    logic       right_dir;
    logic       front_hit;
    logic       rear_hit;
    logic       frame_valid;
    logic       frame_stall;
    logic [7:0] out_byte;
    logic       last_byte;

    // Bytes of predicted frames, oldest first.
    frame_byte_t pending_bytes[$];

    plan_row_t directed_plan [PLAN_ROWS];

    int  mismatches;
    int  cycle_count;
    int  cmds_sent;
    int  bytes_checked;
    int  front_only_cmds;
    int  rear_only_cmds;
    int  both_hit_cmds;
    // While calm is set, neither side idles.
    bit  calm;

    motor_command_frame_builder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .left_dir    (left_dir),
        .right_dir   (right_dir),
        .front_hit   (front_hit),
        .rear_hit    (rear_hit),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    always #CLK_HALF clk = ~clk;

    // Reflected CRC-16 with the 0xA001 polynomial, run over the length byte
    // through the flag byte. The 0xFF header is left out of the sum.
    function automatic logic [15:0] frame_crc(input frame_bytes_t f);
        logic [15:0] acc;
        acc = CRC_INIT;
        for (frame_idx_t k = IDX_LENGTH; k <= IDX_FLAGS; k++)
        begin
            acc = acc ^ {8'h00, f[k]};
            for (int b = 0; b < 8; b++)
            begin
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    // Lays out the frame around the three payload bytes and appends the CRC.
    function automatic frame_bytes_t assemble_frame(input logic [7:0] ls,
                                                    input logic [7:0] rs,
                                                    input logic [7:0] flags);
        frame_bytes_t f;
        logic [15:0]  crc;
        f             = '0;
        f[IDX_HEADER] = HEADER_BYTE;
        f[IDX_LENGTH] = LENGTH_BYTE;
        f[IDX_LEFT]   = ls;
        f[IDX_PAD_L]  = PAD_BYTE;
        f[IDX_RIGHT]  = rs;
        f[IDX_PAD_R]  = PAD_BYTE;
        f[IDX_FLAGS]  = flags;
        crc           = frame_crc(f);
        f[IDX_CRC_LO] = crc[7:0];
        f[IDX_CRC_HI] = crc[15:8];
        return f;
    endfunction

    // Works out the frame for one drive command, collision overrides included.
    // A hit on one side only forces both wheels to the hit speed: a front hit
    // clears both direction flags, a rear hit sets them. Hits on both sides
    // cancel out and the command goes through as given.
    function automatic frame_bytes_t drive_frame(input drive_cmd_t c);
        logic [7:0] ls;
        logic [7:0] rs;
        logic [7:0] flags;
        ls                    = c.left_speed;
        rs                    = c.right_speed;
        flags                 = FLAG_NONE;
        flags[LEFT_FLAG_BIT]  = c.left_dir;
        flags[RIGHT_FLAG_BIT] = c.right_dir;
        if (c.front_hit && !c.rear_hit)
        begin
            ls    = HIT_SPEED;
            rs    = HIT_SPEED;
            flags = FLAG_NONE;
        end
        else if (!c.front_hit && c.rear_hit)
        begin
            ls    = HIT_SPEED;
            rs    = HIT_SPEED;
            flags = FLAG_BOTH;
        end
        return assemble_frame(ls, rs, flags);
    endfunction

    task automatic report_mismatch(input string what, input int frame_no,
                                   input int got, input int want);
        if (mismatches < MAX_REPORTS)
        begin
            $display("[%0t] frame %0d: %s is 0x%0h, should be 0x%0h",
                     $time, frame_no, what, got, want);
        end
        mismatches++;
    endtask

    // Sends one command request. It is entered at a falling edge and leaves
    // at the falling edge after the request was taken. Sometimes the sender
    // idles first, for a random gap, so that the block also
    // runs dry between frames. The payload holds still while cmd_stall is up.
    task automatic send_command(input drive_cmd_t c, input frame_bytes_t want);
        if (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
        end
        cmd_valid   <= 1'b1;
        left_speed  <= c.left_speed;
        right_speed <= c.right_speed;
        left_dir    <= c.left_dir;
        right_dir   <= c.right_dir;
        front_hit   <= c.front_hit;
        rear_hit    <= c.rear_hit;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        // Taken at this edge: queue the nine bytes it must turn into.
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            pending_bytes.push_back('{data: want[frame_idx_t'(k)],
                                      last: (frame_idx_t'(k) == IDX_CRC_HI),
                                      frame_no: cmds_sent});
        end
        cmds_sent++;
        if (c.front_hit && c.rear_hit)
        begin
            both_hit_cmds++;
        end
        else if (c.front_hit)
        begin
            front_only_cmds++;
        end
        else if (c.rear_hit)
        begin
            rear_only_cmds++;
        end
        @(negedge clk);
    endtask

    // The frame receiver stalls now and then, except in the calm stretch.
    always @(negedge clk)
    begin
        frame_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Each frame byte taken from the block is held against the oldest
    // predicted byte. A byte with nothing predicted is a failure of its own.
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("unpredicted frame byte", -1, int'(out_byte), 0);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.data)
                begin
                    report_mismatch("out_byte", want.frame_no, int'(out_byte),
                                    int'(want.data));
                end
                if (last_byte !== want.last)
                begin
                    report_mismatch("last_byte", want.frame_no, int'(last_byte),
                                    int'(want.last));
                end
                bytes_checked++;
            end
        end
    end

    // Guard against a hung block: the run is cut off after a generous limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run timed out with %0d frame bytes outstanding.",
                     pending_bytes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        drive_cmd_t   cmd;
        frame_bytes_t want;
        int           drained;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        left_speed  = '0;
        right_speed = '0;
        left_dir    = 1'b0;
        right_dir   = 1'b0;
        front_hit   = 1'b0;
        rear_hit    = 1'b0;
        frame_stall = 1'b0;
        calm        = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        cmds_sent   = 0;
        bytes_checked   = 0;
        front_only_cmds = 0;
        rear_only_cmds  = 0;
        both_hit_cmds   = 0;

        // Directed commands: field extremes, each direction flag alone, each
        // collision on its own and both together. The hand-typed rows give
        // the speed and flag bytes that must appear in the frame.
        directed_plan = '{
            '{'{8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'd0,   8'd0,   FLAG_NONE},
            '{'{8'd255, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1, 8'd255, 8'd255, FLAG_BOTH},
            '{'{8'd255, 8'd0,   1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, 8'd255, 8'd0,   FLAG_LEFT},
            '{'{8'd0,   8'd255, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, 8'd0,   8'd255, FLAG_RIGHT},
            '{'{8'd17,  8'd34,  1'b1, 1'b1, 1'b1, 1'b0}, 1'b1, 8'd200, 8'd200, FLAG_NONE},
            '{'{8'd5,   8'd6,   1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, 8'd200, 8'd200, FLAG_BOTH},
            '{'{8'd99,  8'd1,   1'b1, 1'b0, 1'b1, 1'b1}, 1'b1, 8'd99,  8'd1,   FLAG_LEFT},
            '{'{8'd0,   8'd255, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, 8'd0,   8'd255, FLAG_RIGHT},
            '{'{8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, 8'd200, 8'd200, FLAG_NONE},
            '{'{8'd0,   8'd0,   1'b1, 1'b1, 1'b0, 1'b1}, 1'b1, 8'd200, 8'd200, FLAG_BOTH},
            '{'{8'hA5,  8'h5A,  1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 8'd0,   8'd0,   FLAG_NONE},
            '{'{8'h5A,  8'hA5,  1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, 8'd0,   8'd0,   FLAG_NONE},
            '{'{8'd200, 8'd200, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 8'd0,   8'd0,   FLAG_NONE},
            '{'{8'h80,  8'h01,  1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 8'd0,   8'd0,   FLAG_NONE}
        };

        // Reset is held from the start and let go at a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
        begin
            cmd  = directed_plan[i].cmd;
            want = directed_plan[i].typed
                   ? assemble_frame(directed_plan[i].want_left,
                                    directed_plan[i].want_right,
                                    directed_plan[i].want_flags)
                   : drive_frame(cmd);
            send_command(cmd, want);
        end

        // Random commands. Speeds lean toward the edges and the hit speed now
        // and then; the flags are drawn freely, so every collision case keeps
        // turning up. A stretch in the middle runs with no idling at all.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST) && (n < CALM_LAST);
            case ($urandom_range(7))
                0: cmd.left_speed = 8'd0;
                1: cmd.left_speed = 8'd255;
                2: cmd.left_speed = HIT_SPEED;
                default: cmd.left_speed = 8'($urandom);
            endcase
            case ($urandom_range(7))
                0: cmd.right_speed = 8'd0;
                1: cmd.right_speed = 8'd255;
                2: cmd.right_speed = HIT_SPEED;
                default: cmd.right_speed = 8'($urandom);
            endcase
            cmd.left_dir  = 1'($urandom);
            cmd.right_dir = 1'($urandom);
            cmd.front_hit = 1'($urandom);
            cmd.rear_hit  = 1'($urandom);
            send_command(cmd, drive_frame(cmd));
        end
        calm = 1'b0;
        cmd_valid <= 1'b0;

        // Let the last frames drain, then watch a little longer for any
        // stray byte. The cycle limit catches a block that never drains.
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        drained = 0;
        while (drained < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drained++;
        end

        $display("Sent %0d drive commands: %0d front-only, %0d rear-only, %0d with both hits.",
                 cmds_sent, front_only_cmds, rear_only_cmds, both_hit_cmds);
        $display("Checked %0d frame bytes against prediction; %0d mismatches.",
                 bytes_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mcfb_pkg.sv
rtl/motor_command_frame_builder.sv
verif/tb.sv
